@@ hw/rtl/pbfs_pkg.sv @@
package pbfs_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_VARINT  = 2'd0,
    OP_LEN     = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_RSVD    = 2'd3
  } op_t;

  // Protobuf wire types placed in the low bits of the key
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_LEN    = 3'd2;

  localparam int FIELD_W   = 29;
  localparam int VALUE_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int GROUP_W   = 7;
  localparam int IN_DATA_W = 72;

  // Byte count of one varint (1..5) and byte index within an item (0..9)
  typedef logic [2:0] vlen_t;
  typedef logic [3:0] bidx_t;

  // Number of base-128 bytes needed for a 32-bit value
  function automatic vlen_t varint_len(input logic [VALUE_W-1:0] x);
    vlen_t len;
    if (|x[31:28]) begin
      len = 3'd5;
    end else if (|x[27:21]) begin
      len = 3'd4;
    end else if (|x[20:14]) begin
      len = 3'd3;
    end else if (|x[13:7]) begin
      len = 3'd2;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Seven-bit group g of a 32-bit value, least significant first
  function automatic logic [GROUP_W-1:0] varint_group(input logic [VALUE_W-1:0] x,
                                                      input vlen_t g);
    logic [GROUP_W-1:0] grp;
    case (g)
      3'd0:    grp = x[6:0];
      3'd1:    grp = x[13:7];
      3'd2:    grp = x[20:14];
      3'd3:    grp = x[27:21];
      3'd4:    grp = {3'b000, x[31:28]};
      default: grp = '0;
    endcase
    return grp;
  endfunction

endpackage

@@ hw/rtl/protobuf_field_serializer.sv @@
// Protobuf field serializer: turns a stream of requests into protobuf wire bytes, one byte per
// cycle on out_tdata while the output is not stalled. A varint header (tuser 0) emits the key
// (field_number<<3 | 0) and then the value as base-128 varints; a length-delimited header
// (tuser 1) emits the key with wire type 2 and then the length; a payload byte (tuser 2) passes
// through; tuser 3 is dropped with no output. Payload streams run at one byte per clock while
// out_tready holds; a header emits as many bytes as its key and value need (2 to 10), through
// the single byte-wide output register. out_tuser flags the last byte of each request,
// out_tlast the last byte of a request that came with in_tlast. The next request is taken in the
// same cycle as the last byte of the current one; while the output is stalled, a request held
// in the input register waits and keeps in_tready low, so the input stalls with the output.
module protobuf_field_serializer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [28:0] field_number, [60:29] value, [68:61] payload_byte, [71:69] zero
  input  logic [pbfs_pkg::IN_DATA_W-1:0] in_tdata,
  // [1:0] op
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] out_byte
  output logic [pbfs_pkg::BYTE_W-1:0]    out_tdata,
  // [0] item_last
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import pbfs_pkg::*;

  // Input register: one request being encoded
  logic                 hold_valid_r, hold_valid_nxt;
  op_t                  op_r;
  logic [VALUE_W-1:0]   key_r;
  logic [VALUE_W-1:0]   value_r;
  logic [BYTE_W-1:0]    pbyte_r;
  logic                 mend_r;
  vlen_t                key_len_r;
  vlen_t                val_len_r;
  bidx_t                idx_r, idx_nxt;

  // Result register
  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]    out_byte_r;
  logic                 out_item_last_r;
  logic                 out_msg_done_r;

  logic                 out_adv;
  logic                 emit;
  logic                 is_last;
  logic                 in_acc;
  logic                 key_phase;
  vlen_t                vidx;
  bidx_t                last_idx;
  logic [BYTE_W-1:0]    byte_c;
  op_t                  in_op;
  logic [VALUE_W-1:0]   in_key;
  logic [2:0]           in_wire;

  assign in_op  = op_t'(in_tuser);
  assign in_acc = in_tvalid && in_tready;

  // Build the key from the incoming field number
  always_comb begin
    in_wire = (in_op == OP_LEN) ? WIRE_LEN : WIRE_VARINT;
    in_key  = {in_tdata[FIELD_W-1:0], in_wire};
  end

  // Pick the byte at the current index
  always_comb begin
    out_adv   = !out_valid_r || out_tready;
    emit      = hold_valid_r && out_adv;
    key_phase = idx_r < {1'b0, key_len_r};
    vidx      = idx_r[2:0] - key_len_r;
    last_idx  = {1'b0, key_len_r} + {1'b0, val_len_r} - 4'd1;
    case (op_r)
      OP_PAYLOAD: begin
        byte_c  = pbyte_r;
        is_last = 1'b1;
      end
      OP_VARINT, OP_LEN: begin
        if (key_phase) begin
          byte_c = {idx_r[2:0] != key_len_r - 3'd1, varint_group(key_r, idx_r[2:0])};
        end else begin
          byte_c = {vidx != val_len_r - 3'd1, varint_group(value_r, vidx)};
        end
        is_last = idx_r == last_idx;
      end
      default: begin
        byte_c  = '0;
        is_last = 1'b1;
      end
    endcase
  end

  // Take a new request once the current one sends its last byte
  assign in_tready = !hold_valid_r || (emit && is_last);

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    idx_nxt        = idx_r;
    if (in_acc) begin
      hold_valid_nxt = in_op != OP_RSVD;
      idx_nxt        = '0;
    end else if (emit) begin
      hold_valid_nxt = !is_last;
      idx_nxt        = idx_r + 4'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_adv ? 1'b0 : out_valid_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_op;
      key_r     <= in_key;
      value_r   <= in_tdata[FIELD_W+VALUE_W-1:FIELD_W];
      pbyte_r   <= in_tdata[FIELD_W+VALUE_W+BYTE_W-1:FIELD_W+VALUE_W];
      mend_r    <= in_tlast;
      key_len_r <= varint_len(in_key);
      val_len_r <= varint_len(in_tdata[FIELD_W+VALUE_W-1:FIELD_W]);
    end
    if (emit) begin
      out_byte_r      <= byte_c;
      out_item_last_r <= is_last;
      out_msg_done_r  <= is_last && mend_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_item_last_r;
  assign out_tlast  = out_msg_done_r;

`ifndef ASSERT_OFF
  // Byte index never runs past the last byte of a header
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && (op_r == OP_VARINT || op_r == OP_LEN) |-> idx_r <= last_idx)
    else $error("byte index beyond end of header");

  // A payload request sends exactly one byte
  a_payload_one: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r && op_r == OP_PAYLOAD |-> idx_r == '0)
    else $error("payload request past its only byte");

  // A new request replaces a busy one only as its last byte goes out
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && hold_valid_r |-> emit && is_last)
    else $error("request accepted over unfinished one");

  // Message end only marks a request's last byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("message end without request end");
`endif

endmodule
